### rtl/gsvu_pkg.sv
// Shared types and constants for the gain stage and peak level meter.
package gsvu_pkg;

    // Configuration port
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DB = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DB = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 8'd3;

    localparam logic [15:0] GAIN_RST   = 16'd4096;
    localparam logic [15:0] MIN_DB_RST = 16'hD800;   // -40.0 dB in Q7.8
    localparam logic [15:0] MAX_DB_RST = 16'h0000;
    localparam logic [15:0] WINDOW_RST = 16'd4800;

    // 20*log10(2)*256 in Q.16
    localparam logic [26:0] DB_PER_OCTAVE = 27'd101008905;

    // Last iteration index of the log and divide loops
    localparam logic [3:0] LOG_LAST = 4'd15;
    localparam logic [3:0] DIV_LAST = 4'd15;

    // log2 in Q.16 by repeated squaring, evaluated at elaboration only
    function automatic logic [19:0] log2_q16_const(input logic [14:0] p);
        logic [3:0]  e;
        logic [15:0] frac;
        logic [63:0] m;
        e = 4'd0;
        for (int i = 1; i < 15; i++)
        begin
            if (p[i])
            begin
                e = 4'(i);
            end
        end
        m = 64'(p) << (4'd15 - e);
        frac = 16'd0;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 15;
            frac = {frac[14:0], 1'b0};
            if (m >= 64'd65536)
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return {e, frac};
    endfunction

    // log2 of full scale (32767)
    localparam logic [19:0] LOG2_FULL = log2_q16_const(15'd32767);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic in_ready;
        logic take;
        logic mul;
        logic sat;
        logic log_init;
        logic log_step;
        logic db_mul;
        logic db_fix;
        logic vu_prep;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic close;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/gsvu_in_if.sv
// Sample input channel.
interface gsvu_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

### rtl/gsvu_out_if.sv
// Result channel: scaled sample and meter report.
interface gsvu_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;
    logic               meter_valid;
    logic [14:0]        peak_level;
    logic signed [15:0] peak_db;
    logic [15:0]        peak_vu;

    modport source (output valid, output sample_out, output meter_valid, output peak_level,
                    output peak_db, output peak_vu, input ready);
    modport sink   (input valid, input sample_out, input meter_valid, input peak_level,
                    input peak_db, input peak_vu, output ready);
endinterface

### rtl/gsvu_cfg_if.sv
// Configuration write channel.
interface gsvu_cfg_if;
    import gsvu_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/gain_saturate_peak_vu_meter.sv
// Top level: gain stage with peak level meter, configuration registers.
//
// Usage:
//   samples  - one signed 16-bit PCM sample per beat (valid/ready).
//   results  - one beat per sample: the scaled, rounded, saturated sample;
//              on the beat that closes a window, also meter_valid, the peak,
//              the peak in Q7.8 dB and the VU ratio (all zero otherwise).
//   cfg      - register writes (index, data); always ready. Write only while
//              no sample is in flight. Index 0 gain, 1 min dB, 2 max dB,
//              3 window length; other indexes are ignored.
// Sequence:
//   A sample that does not close a window steps through the multiply, saturate
//   and done states; the next beat is accepted only after its result has been
//   loaded into the output register. A closing sample also runs the 16-step
//   squaring log2 loop, the dB steps and the 16-step divider for the VU ratio.
// Reset clears peak, sample count and the output valid flag; registers take
//   their defaults (unity gain, -40 dB to 0 dB, 4800-sample window).
// When the receiver stalls the result holds in the output register; one more
//   sample is accepted and processed, then the input waits for the slot.
module gain_saturate_peak_vu_meter
    import gsvu_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    gsvu_in_if.sink      samples,
    gsvu_out_if.source   results,
    gsvu_cfg_if.sink     cfg
);

    logic [15:0] gain_reg;
    logic [15:0] min_db_reg;
    logic [15:0] max_db_reg;
    logic [15:0] window_reg;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RST;
            min_db_reg <= MIN_DB_RST;
            max_db_reg <= MAX_DB_RST;
            window_reg <= WINDOW_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_GAIN:   gain_reg   <= cfg.data;
                REG_MIN_DB: min_db_reg <= cfg.data;
                REG_MAX_DB: max_db_reg <= cfg.data;
                REG_WINDOW: window_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    // Controller
    gsvu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .status   (status),
        .cmd      (cmd)
    );

    assign samples.ready = cmd.in_ready;

    // Datapath
    gsvu_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample_in      (samples.sample_in),
        .gain           (gain_reg),
        .min_level_db   (min_db_reg),
        .max_level_db   (max_db_reg),
        .window_samples (window_reg),
        .out_valid      (results.valid),
        .out_ready      (results.ready),
        .sample_out     (results.sample_out),
        .meter_valid    (results.meter_valid),
        .peak_level     (results.peak_level),
        .peak_db        (results.peak_db),
        .peak_vu        (results.peak_vu)
    );

`ifndef SYNTHESIS
    // Meter fields stay zero on beats that do not close a window
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.meter_valid) |->
            (results.peak_level == 15'd0 && results.peak_db == 16'sd0
             && results.peak_vu == 16'd0))
        else $error("meter fields set on a non-closing beat");

    // Only one sample in flight: input closes right after a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("second sample accepted while busy");

    // A new result only enters the output register when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!results.valid || results.ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

### rtl/gsvu_ctrl.sv
// Sequencer for the gain, log and divide steps of one sample.
module gsvu_ctrl
    import gsvu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SAT   = 4'd2;
    localparam logic [3:0] S_LINIT = 4'd3;
    localparam logic [3:0] S_LOG   = 4'd4;
    localparam logic [3:0] S_DBMUL = 4'd5;
    localparam logic [3:0] S_DBFIX = 4'd6;
    localparam logic [3:0] S_VUP   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] iter_reg;
    logic [3:0] iter_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = status.close ? S_LINIT : S_DONE;
            end
            S_LINIT:
            begin
                cmd.log_init = 1'b1;
                iter_next    = 4'd0;
                state_next   = S_LOG;
            end
            S_LOG:
            begin
                cmd.log_step = 1'b1;
                iter_next    = iter_reg + 4'd1;
                if (iter_reg == LOG_LAST)
                begin
                    state_next = S_DBMUL;
                end
            end
            S_DBMUL:
            begin
                cmd.db_mul = 1'b1;
                state_next = S_DBFIX;
            end
            S_DBFIX:
            begin
                cmd.db_fix = 1'b1;
                state_next = S_VUP;
            end
            S_VUP:
            begin
                cmd.vu_prep = 1'b1;
                iter_next   = 4'd0;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 4'd1;
                if (iter_reg == DIV_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

### rtl/gsvu_dp.sv
// Datapath: gain multiply, saturation, peak and count, log, dB and VU divide.
module gsvu_dp
    import gsvu_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic signed [15:0] sample_in,
    input  logic [15:0]        gain,
    input  logic [15:0]        min_level_db,
    input  logic [15:0]        max_level_db,
    input  logic [15:0]        window_samples,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample_out,
    output logic               meter_valid,
    output logic [14:0]        peak_level,
    output logic signed [15:0] peak_db,
    output logic [15:0]        peak_vu
);

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // Control state
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [14:0]           peak_reg;
    logic                  out_valid_reg;

    // Payload registers
    logic signed [15:0] sample_reg;
    logic signed [32:0] prod_reg;
    logic signed [15:0] sout_reg;
    logic               close_reg;
    logic [14:0]        rep_peak_reg;
    logic [3:0]         exp_reg;
    logic [15:0]        mant_reg;
    logic [15:0]        frac_reg;
    logic [46:0]        dq_reg;
    logic signed [15:0] db_reg;
    logic               vu_en_reg;
    logic [15:0]        div_r_reg;
    logic [15:0]        rem_reg;
    logic [15:0]        quo_reg;
    logic signed [15:0] sample_out_reg;
    logic               meter_valid_reg;
    logic [14:0]        peak_level_reg;
    logic signed [15:0] peak_db_reg;
    logic [15:0]        peak_vu_reg;

    // Round half away from zero and saturate
    logic [32:0]           mag;
    logic [32:0]           mag_rnd;
    logic [20:0]           rnd;
    logic [14:0]           amag;
    logic signed [15:0]    sout_next;
    logic [14:0]           peak_next;
    logic [COUNT_BITS-1:0] cnt_next;

    always_comb
    begin
        mag     = prod_reg[32] ? 33'(~prod_reg + 33'd1) : 33'(prod_reg);
        mag_rnd = mag + 33'd2048;
        rnd     = mag_rnd[32:12];
        amag    = (rnd > 21'd32767) ? 15'h7FFF : rnd[14:0];
        if (!prod_reg[32])
        begin
            sout_next = {1'b0, amag};
        end
        else if (rnd >= 21'd32768)
        begin
            sout_next = 16'sh8000;
        end
        else
        begin
            sout_next = 16'(~{1'b0, rnd[14:0]} + 16'd1);
        end
        peak_next = (amag > peak_reg) ? amag : peak_reg;
    end

    // Saturating sample count and window compare
    assign cnt_next = (cnt_reg == '1) ? cnt_reg : cnt_reg + COUNT_BITS'(1);
    assign status.close = (CMP_W'(cnt_next) >= CMP_W'(window_samples));

    // Top set bit of the reported peak
    logic [3:0]  lead;
    logic [15:0] mant_init;

    always_comb
    begin
        lead = 4'd0;
        for (int i = 1; i < 15; i++)
        begin
            if (rep_peak_reg[i])
            begin
                lead = 4'(i);
            end
        end
        mant_init = {1'b0, rep_peak_reg} << (4'd15 - lead);
    end

    // One fraction bit per squaring
    logic [31:0] mant_sq;
    logic [16:0] mant_sh;

    assign mant_sq = 32'(mant_reg) * 32'(mant_reg);
    assign mant_sh = mant_sq[31:15];

    // Octaves below full scale times dB per octave
    logic [19:0] log_diff;
    logic [46:0] dq_next;

    assign log_diff = LOG2_FULL - {exp_reg, frac_reg};
    assign dq_next  = {27'd0, log_diff} * {20'd0, DB_PER_OCTAVE};

    // Round, negate and floor at the lower bound
    logic [46:0]        dq_rnd;
    logic signed [16:0] db_raw;
    logic signed [16:0] mn_ext;
    logic signed [16:0] mx_ext;
    logic signed [15:0] db_next;

    always_comb
    begin
        dq_rnd = dq_reg + 47'h0000_8000_0000;
        mn_ext = {min_level_db[15], min_level_db};
        mx_ext = {max_level_db[15], max_level_db};
        if (rep_peak_reg == 15'd0)
        begin
            db_raw = -17'sd32768;
        end
        else
        begin
            db_raw = 17'(~{2'b00, dq_rnd[46:32]} + 17'd1);
        end
        db_next = (db_raw < mn_ext) ? min_level_db : db_raw[15:0];
    end

    // VU range, threshold and dividend
    logic signed [16:0] db_ext;
    logic signed [16:0] db_clamp;
    logic signed [16:0] n_ext;
    logic signed [16:0] r_ext;
    logic [15:0]        n16;
    logic [15:0]        r16;
    logic [19:0]        n_x10;
    logic [19:0]        r_x3;
    logic               vu_en;
    logic [31:0]        dividend;

    always_comb
    begin
        db_ext   = {db_reg[15], db_reg};
        db_clamp = (db_ext > mx_ext) ? mx_ext : db_ext;
        n_ext    = db_clamp - mn_ext;
        r_ext    = mx_ext - mn_ext;
        n16      = n_ext[15:0];
        r16      = r_ext[15:0];
        n_x10    = 20'(n16) * 20'd10;
        r_x3     = 20'(r16) * 20'd3;
        vu_en    = (mx_ext > mn_ext) && (n_x10 >= r_x3);
        dividend = {n16, 16'd0} - 32'(n16) + 32'(r16 >> 1);
    end

    // Restoring divide step
    logic [16:0] div_trial;
    logic        div_ge;
    logic [16:0] div_diff;

    assign div_trial = {rem_reg, quo_reg[15]};
    assign div_ge    = (div_trial >= {1'b0, div_r_reg});
    assign div_diff  = div_trial - {1'b0, div_r_reg};

    // Peak, count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            peak_reg      <= 15'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sat)
            begin
                if (status.close)
                begin
                    cnt_reg  <= '0;
                    peak_reg <= 15'd0;
                end
                else
                begin
                    cnt_reg  <= cnt_next;
                    peak_reg <= peak_next;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sample_reg <= sample_in;
        end
        if (cmd.mul)
        begin
            prod_reg <= 33'(sample_reg) * 33'($signed({1'b0, gain}));
        end
        if (cmd.sat)
        begin
            sout_reg     <= sout_next;
            close_reg    <= status.close;
            rep_peak_reg <= peak_next;
        end
        if (cmd.log_init)
        begin
            exp_reg  <= lead;
            mant_reg <= mant_init;
            frac_reg <= 16'd0;
        end
        if (cmd.log_step)
        begin
            if (mant_sh[16])
            begin
                mant_reg <= mant_sh[16:1];
                frac_reg <= {frac_reg[14:0], 1'b1};
            end
            else
            begin
                mant_reg <= mant_sh[15:0];
                frac_reg <= {frac_reg[14:0], 1'b0};
            end
        end
        if (cmd.db_mul)
        begin
            dq_reg <= dq_next;
        end
        if (cmd.db_fix)
        begin
            db_reg <= db_next;
        end
        if (cmd.vu_prep)
        begin
            vu_en_reg <= vu_en;
            div_r_reg <= r16;
            rem_reg   <= dividend[31:16];
            quo_reg   <= dividend[15:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_diff[15:0] : div_trial[15:0];
            quo_reg <= {quo_reg[14:0], div_ge};
        end
        if (cmd.out_load)
        begin
            sample_out_reg  <= sout_reg;
            meter_valid_reg <= close_reg;
            peak_level_reg  <= close_reg ? rep_peak_reg : 15'd0;
            peak_db_reg     <= close_reg ? db_reg : 16'sd0;
            peak_vu_reg     <= (close_reg && vu_en_reg) ? quo_reg : 16'd0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign meter_valid = meter_valid_reg;
    assign peak_level  = peak_level_reg;
    assign peak_db     = peak_db_reg;
    assign peak_vu     = peak_vu_reg;

endmodule
